@@ sv/rlse_pkg.sv @@
package rlse_pkg;

  // Default string capacity
  localparam int unsigned MaxLenDef = 64;

  // Alphabet size for the cyclic shift
  localparam logic [5:0] LetterMod = 6'd26;

  // Request codes
  localparam logic [1:0] ReqLoad   = 2'd0;
  localparam logic [1:0] ReqShift  = 2'd1;
  localparam logic [1:0] ReqFinish = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] letter_in;
    logic [5:0] range_start;
    logic [5:0] range_end;
    logic       forward;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [4:0] letter_out;
    logic [5:0] position;
    logic       last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic shift_rd;
    logic shift_wr0;
    logic shift_wr1;
    logic fin_start;
    logic fin_emit;
    logic clear;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic range_ok;
    logic len_zero;
    logic last_idx;
    logic out_free;
  } sts_t;

  // Add two letter values modulo 26
  function automatic logic [4:0] add_mod26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= LetterMod) begin
      s = s - LetterMod;
    end
    return s[4:0];
  endfunction

endpackage

@@ sv/rlse_ctrl.sv @@
module rlse_ctrl
  import rlse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WR0,
    S_WR1,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            ReqLoad: begin
              cmd_o.load = 1'b1;
            end
            ReqShift: begin
              if (sts_i.range_ok) begin
                cmd_o.shift_rd = 1'b1;
                state_d        = S_WR0;
              end
            end
            ReqFinish: begin
              if (sts_i.len_zero) begin
                cmd_o.clear = 1'b1;
              end else begin
                cmd_o.fin_start = 1'b1;
                state_d         = S_FIN;
              end
            end
            default: begin
              // drop unused request code
            end
          endcase
        end
      end
      S_WR0: begin
        cmd_o.shift_wr0 = 1'b1;
        state_d         = S_WR1;
      end
      S_WR1: begin
        cmd_o.shift_wr1 = 1'b1;
        state_d         = S_IDLE;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin_emit = 1'b1;
          if (sts_i.last_idx) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    ready_d = (state_d == S_IDLE);
  end

  // Hold state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

endmodule

@@ sv/rlse_dp.sv @@
module rlse_dp
  import rlse_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned Depth = MAX_LEN + 1;
  localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DAW   = $clog2(Depth);
  localparam int unsigned LW    = $clog2(Depth);

  // Storage
  logic [4:0]       letter_mem [MAX_LEN];
  logic [4:0]       diff_mem   [Depth];
  logic [Depth-1:0] diff_vld_q;

  // Control registers
  logic [LW-1:0]  len_q;
  logic [AW-1:0]  idx_q;
  logic [4:0]     run_q;
  logic [DAW-1:0] first_q;
  logic [DAW-1:0] endp1_q;
  logic           fwd_q;

  // Read data registers
  logic [4:0] letter_rd_q;
  logic [4:0] diff_a_q;
  logic [4:0] diff_b_q;
  logic       vld_a_q;
  logic       vld_b_q;

  // Output register
  out_t out_q;
  logic out_valid_q;

  logic [6:0]     idx_p1;
  logic [DAW-1:0] addr_a;
  logic [DAW-1:0] addr_b;
  logic [AW-1:0]  letter_addr;
  logic           rd_diff;
  logic           rd_letter;
  logic           full;
  logic [4:0]     letter_mod;
  logic [4:0]     diff_a;
  logic [4:0]     diff_b;
  logic [4:0]     run_n;
  logic [4:0]     step_up;
  logic [4:0]     step_down;
  logic           wr_en;
  logic [DAW-1:0] wr_addr;
  logic [4:0]     wr_data;

  assign idx_p1 = 7'(idx_q) + 7'd1;
  assign full   = (len_q == LW'(MAX_LEN));

  // Status towards the controller
  assign sts_o.range_ok = (in_data_i.range_start <= in_data_i.range_end) &&
                          (7'(in_data_i.range_end) < 7'(len_q));
  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.last_idx = (idx_p1 == 7'(len_q));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Select read addresses
  always_comb begin
    addr_a      = DAW'(idx_p1);
    letter_addr = AW'(idx_p1);
    if (cmd_i.shift_rd) begin
      addr_a = DAW'(in_data_i.range_start);
    end else if (cmd_i.fin_start) begin
      addr_a      = '0;
      letter_addr = '0;
    end
  end
  assign addr_b    = DAW'(7'(in_data_i.range_end) + 7'd1);
  assign rd_diff   = cmd_i.shift_rd || cmd_i.fin_start || cmd_i.fin_emit;
  assign rd_letter = cmd_i.fin_start || cmd_i.fin_emit;

  // Unwritten difference entries read as zero
  assign diff_a = vld_a_q ? diff_a_q : 5'd0;
  assign diff_b = vld_b_q ? diff_b_q : 5'd0;

  assign step_up   = fwd_q ? 5'd1 : 5'd25;
  assign step_down = fwd_q ? 5'd25 : 5'd1;

  // Difference store write port
  always_comb begin
    wr_en   = cmd_i.shift_wr0 || cmd_i.shift_wr1;
    wr_addr = cmd_i.shift_wr0 ? first_q : endp1_q;
    wr_data = cmd_i.shift_wr0 ? add_mod26(diff_a, step_up) : add_mod26(diff_b, step_down);
  end

  assign letter_mod = (in_data_i.letter_in >= LetterMod[4:0]) ?
                      (in_data_i.letter_in - LetterMod[4:0]) : in_data_i.letter_in;

  assign run_n = add_mod26(run_q, diff_a);

  // Letter store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      letter_mem[len_q[AW-1:0]] <= letter_mod;
    end
    if (rd_letter) begin
      letter_rd_q <= letter_mem[letter_addr];
    end
  end

  // Difference store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      diff_mem[wr_addr] <= wr_data;
    end
    if (rd_diff) begin
      diff_a_q <= diff_mem[addr_a];
      diff_b_q <= diff_mem[addr_b];
    end
  end

  // Capture shift operands and emit payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_rd) begin
      first_q <= DAW'(in_data_i.range_start);
      endp1_q <= addr_b;
      fwd_q   <= in_data_i.forward;
    end
    if (cmd_i.fin_emit) begin
      out_q.letter_out <= add_mod26(letter_rd_q, run_n);
      out_q.position   <= 6'(idx_q);
      out_q.last       <= sts_o.last_idx;
    end
  end

  // Control state: length, walk index, running sum, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      idx_q       <= '0;
      run_q       <= '0;
      diff_vld_q  <= '0;
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && !full) begin
        len_q <= len_q + LW'(1);
      end
      if (rd_diff) begin
        vld_a_q <= diff_vld_q[addr_a];
        vld_b_q <= diff_vld_q[addr_b];
      end
      if (wr_en) begin
        diff_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.fin_start) begin
        idx_q <= '0;
        run_q <= '0;
      end else if (cmd_i.fin_emit) begin
        idx_q <= AW'(idx_p1);
        run_q <= run_n;
      end
      if (cmd_i.clear) begin
        len_q      <= '0;
        diff_vld_q <= '0;
      end
      if (cmd_i.fin_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/range_letter_shift_engine_core.sv @@
// Range letter shift engine. Load items append one letter (0..25, larger codes
// stored modulo 26). Shift items record +1/-1 over an inclusive range as two
// updates of a difference store: one read of both ends, then one write each, set
// by the single write port of that store. A finish item walks the string with a
// running prefix sum and emits one shifted letter per cycle while the result side
// takes them; the store and length are then cleared at once.
// Out-of-range shifts, loads past MAX_LEN and request code 3 are dropped.
module range_letter_shift_engine_core
  import rlse_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each transaction
  rlse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (in_data_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, walk and result register
  rlse_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rlse_pkg::*;

  localparam int unsigned StrCap      = MaxLenDef;
  localparam logic [1:0]  ReqUnused   = 2'd3;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned HoldOffAt   = 150;
  localparam int unsigned HoldOffLen  = 400;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic drain_first;
    in_t  req;
  } pending_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Shadow copy of the string, the difference store and the length
  logic [4:0]  letter_mem [StrCap];
  logic [4:0]  diff_mem [StrCap+1];
  int unsigned str_len = 0;

  pending_t    pending_items[$];
  out_t        expected_letters[$];
  pending_t    head_item;
  out_t        oldest_letter;
  bit          drain_next  = 1'b0;
  logic        all_drained = 1'b1;

  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned offered_count = 0;
  int unsigned taken_count   = 0;
  int unsigned accepted_items = 0;
  int unsigned checked_count = 0;
  int unsigned finish_count  = 0;
  int unsigned dropped_shifts = 0;
  int unsigned ignored_loads = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;

  range_letter_shift_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one accepted request to the shadow state, queue the letters it emits
  task automatic apply_letter_request(input in_t req);
    int unsigned run;
    int unsigned step;
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    out_t res;
    case (req.req_type)
      ReqLoad: begin
        if (str_len < StrCap) begin
          v = req.letter_in % 26;
          letter_mem[str_len] = v[4:0];
          str_len++;
        end else begin
          ignored_loads++;
        end
      end
      ReqShift: begin
        if (req.range_start <= req.range_end && req.range_end < str_len) begin
          step = req.forward ? 1 : 25;
          lo = 32'(req.range_start);
          hi = 32'(req.range_end);
          hi = hi + 1;
          v = (diff_mem[lo] + step) % 26;
          diff_mem[lo] = v[4:0];
          v = (diff_mem[hi] + 26 - step) % 26;
          diff_mem[hi] = v[4:0];
        end else begin
          dropped_shifts++;
        end
      end
      ReqFinish: begin
        run = 0;
        for (int i = 0; i < str_len; i++) begin
          run = (run + diff_mem[i]) % 26;
          v = (letter_mem[i] + run) % 26;
          res.letter_out = v[4:0];
          res.position   = i[5:0];
          res.last       = (i + 1 == str_len);
          expected_letters.push_back(res);
        end
        for (int i = 0; i <= StrCap; i++) begin
          diff_mem[i] = '0;
        end
        str_len = 0;
        finish_count++;
      end
      default: ;
    endcase
  endtask

  // Queue one request; a pending drain mark goes onto it
  task automatic push_item(input logic [1:0] kind, input logic [4:0] letter,
                           input logic [5:0] first_pos, input logic [5:0] last_pos,
                           input logic fwd);
    pending_t p;
    p.drain_first       = drain_next;
    p.req.req_type      = kind;
    p.req.letter_in     = letter;
    p.req.range_start   = first_pos;
    p.req.range_end     = last_pos;
    p.req.forward       = fwd;
    pending_items.push_back(p);
    drain_next = 1'b0;
  endtask

  // Driver: offer pending requests with a random gap after each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        offered_count++;
        send_gap = (offered_count >= 200 && offered_count < 280) ? 0 : $urandom_range(0, 8);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        head_item = pending_items[0];
        // A drain-marked request waits for an idle cycle with nothing outstanding
        if (!head_item.drain_first || (!in_valid_i && all_drained)) begin
          void'(pending_items.pop_front());
          in_valid_i <= 1'b1;
          in_data_i  <= head_item.req;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall at random after each result, once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        taken_count++;
        recv_gap = (taken_count >= 260 && taken_count < 340) ? 0 : $urandom_range(0, 8);
        if (taken_count == HoldOffAt) begin
          recv_gap = HoldOffLen;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_drained <= 1'b1;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_letter_request(in_data_i);
        accepted_items++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_letters.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("unexpected result: letter %0d position %0d last %0b",
                     out_data_o.letter_out, out_data_o.position, out_data_o.last);
          end
        end else begin
          oldest_letter = expected_letters.pop_front();
          checked_count++;
          if (out_data_o.letter_out !== oldest_letter.letter_out ||
              out_data_o.position !== oldest_letter.position ||
              out_data_o.last !== oldest_letter.last) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("mismatch: expected letter %0d position %0d last %0b, got %0d %0d %0b",
                       oldest_letter.letter_out, oldest_letter.position, oldest_letter.last,
                       out_data_o.letter_out, out_data_o.position, out_data_o.last);
            end
          end
        end
      end
      all_drained <= (expected_letters.size() == 0);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_letters.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned made;
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned str_idx;

    for (int i = 0; i <= StrCap; i++) begin
      diff_mem[i] = '0;
    end
    for (int i = 0; i < StrCap; i++) begin
      letter_mem[i] = '0;
    end

    // Directed: empty finish, shift with nothing loaded, unused code
    push_item(ReqFinish, 5'd0, 6'd0, 6'd0, 1'b0);
    push_item(ReqShift, 5'd0, 6'd0, 6'd0, 1'b1);
    push_item(ReqUnused, 5'd31, 6'd63, 6'd63, 1'b1);
    // Letter extremes, codes past z folded back
    push_item(ReqLoad, 5'd0, 6'd63, 6'd0, 1'b1);
    push_item(ReqLoad, 5'd25, 6'd0, 6'd63, 1'b0);
    push_item(ReqLoad, 5'd26, 6'd0, 6'd0, 1'b0);
    push_item(ReqLoad, 5'd31, 6'd0, 6'd0, 1'b0);
    push_item(ReqLoad, 5'd13, 6'd0, 6'd0, 1'b0);
    // Shifts up to the last loaded position, backward wrap below a, forward past z
    push_item(ReqShift, 5'd0, 6'd0, 6'd4, 1'b1);
    push_item(ReqShift, 5'd0, 6'd1, 6'd3, 1'b0);
    push_item(ReqShift, 5'd0, 6'd2, 6'd2, 1'b0);
    push_item(ReqShift, 5'd0, 6'd2, 6'd2, 1'b0);
    push_item(ReqShift, 5'd0, 6'd1, 6'd1, 1'b1);
    push_item(ReqShift, 5'd0, 6'd0, 6'd0, 1'b0);
    // Reversed range, range past the length, top position
    push_item(ReqShift, 5'd0, 6'd3, 6'd1, 1'b1);
    push_item(ReqShift, 5'd0, 6'd0, 6'd5, 1'b1);
    push_item(ReqShift, 5'd0, 6'd63, 6'd63, 1'b0);
    push_item(ReqUnused, 5'd0, 6'd0, 6'd0, 1'b0);
    push_item(ReqFinish, 5'd31, 6'd63, 6'd63, 1'b1);
    // Single letter string
    drain_next = 1'b1;
    push_item(ReqLoad, 5'd7, 6'd0, 6'd0, 1'b0);
    push_item(ReqShift, 5'd0, 6'd0, 6'd0, 1'b0);
    push_item(ReqFinish, 5'd0, 6'd0, 6'd0, 1'b0);

    // Random strings: loads, mostly valid shifts, some noise, then finish
    made = 0;
    str_idx = 0;
    while (made < RandomItems) begin
      if (str_idx == 0 || str_idx == 17 || $urandom_range(0, 9) == 0) begin
        len = StrCap;
      end else begin
        len = $urandom_range(0, 12);
      end
      if (str_idx == 3 || $urandom_range(0, 7) == 0) begin
        drain_next = 1'b1;
      end
      repeat (len) begin
        push_item(ReqLoad, 5'($urandom_range(0, 31)), 6'($urandom), 6'($urandom),
                  1'($urandom));
        made++;
      end
      if (len == StrCap) begin
        repeat ($urandom_range(1, 3)) begin
          push_item(ReqLoad, 5'($urandom_range(0, 31)), 6'($urandom), 6'($urandom),
                    1'($urandom));
        end
      end
      repeat ($urandom_range(0, 8)) begin
        if (len > 0 && $urandom_range(0, 4) != 0) begin
          lo = $urandom_range(0, len - 1);
          hi = $urandom_range(lo, len - 1);
        end else begin
          lo = $urandom_range(0, 63);
          hi = $urandom_range(0, 63);
        end
        push_item(ReqShift, 5'($urandom), lo[5:0], hi[5:0], 1'($urandom));
        made++;
      end
      if ($urandom_range(0, 7) == 0) begin
        push_item(ReqUnused, 5'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
      end
      push_item(ReqFinish, 5'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
      made++;
      str_idx++;
    end

    // Hold reset, then release it at a clock edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all requests to go in and all letters to come out
    do @(posedge clk_i); while (pending_items.size() != 0 || in_valid_i);
    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (expected_letters.size() != 0) begin
      error_count += expected_letters.size();
      $display("%0d expected results never arrived", expected_letters.size());
    end
    $display("summary: %0d input transactions, %0d finishes, %0d letters checked",
             accepted_items, finish_count, checked_count);
    $display("summary: %0d shifts dropped, %0d loads past capacity, %0d errors",
             dropped_shifts, ignored_loads, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rlse_pkg.sv
sv/rlse_ctrl.sv
sv/rlse_dp.sv
sv/range_letter_shift_engine_core.sv
verif/testbench.sv
